// ===== rtl/lfc_pkg.sv =====
// Shared types and constants for the length-prefixed frame checker.
package lfc_pkg;

  // Comparison width for counts, lengths and header sizes (frames up to 255 bytes)
  localparam int CMP_W = 9;

  localparam logic [4:0] HDR_RESET = 5'd11;
  localparam logic [8:0] HDR_MIN   = 9'd2;

  // Result item kinds
  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_EMPTY    = 2'd1;
  localparam logic [1:0] KIND_MISMATCH = 2'd2;
  localparam logic [1:0] KIND_BAD_LEN  = 2'd3;

  // Outcome of the byte on the input channel
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_BAD_LEN  = 3'd1;
  localparam logic [2:0] EV_MISMATCH = 3'd2;
  localparam logic [2:0] EV_EMPTY    = 3'd3;
  localparam logic [2:0] EV_REPLAY   = 3'd4;

  typedef struct packed {
    logic       accept;
    logic       load_status;
    logic [1:0] status_kind;
    logic       start_replay;
    logic       emit;
  } lfc_cmd_t;

  typedef struct packed {
    logic [2:0] evt;
    logic       out_free;
    logic       rd_last;
  } lfc_stat_t;

endpackage

// ===== rtl/length_prefixed_frame_checker.sv =====
// Length-prefixed frame checker: one byte taken per cycle while idle and the output is free.
// A byte that closes a frame yields its status item on the output in the next cycle.
// A good frame's payload is replayed from the store, each byte by a store read and then
// an output load once the output is free; no byte is taken until the replay ends.
// Synchronous active-low reset clears counters, sums and control; header_bytes resets to 11.
module length_prefixed_frame_checker
  import lfc_pkg::*;
#(
  parameter int MAX_FRAME = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_header_bytes,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_payload_byte,
  output logic [1:0] out_item_kind,
  output logic       out_last_item
);

  lfc_cmd_t  cmd;
  lfc_stat_t stat;

  assign cfg_ready = 1'b1;

  lfc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lfc_datapath #(
    .MAX_FRAME (MAX_FRAME)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_header_bytes (cfg_header_bytes),
    .in_data_byte     (in_data_byte),
    .out_stall        (out_stall),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_payload_byte (out_payload_byte),
    .out_item_kind    (out_item_kind),
    .out_last_item    (out_last_item)
  );

endmodule

// ===== rtl/lfc_datapath.sv =====
// Frame store, counters, checksum and output register of the frame checker.
module lfc_datapath
  import lfc_pkg::*;
#(
  parameter int MAX_FRAME = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_header_bytes,
  input  logic [7:0]  in_data_byte,
  input  logic        out_stall,
  input  lfc_cmd_t    cmd,
  output lfc_stat_t   stat,
  output logic        out_valid,
  output logic [7:0]  out_payload_byte,
  output logic [1:0]  out_item_kind,
  output logic        out_last_item
);

  localparam int CW = $clog2(MAX_FRAME + 1);
  localparam int AW = $clog2(MAX_FRAME);
  localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_FRAME);

  logic [7:0]    mem [MAX_FRAME];
  logic [7:0]    rd_data_r;

  logic [4:0]    header_bytes_r;
  logic [CW-1:0] bytes_received_r, bytes_received_nxt;
  logic [7:0]    frame_length_r, frame_length_nxt;
  logic [7:0]    expected_sum_r, expected_sum_nxt;
  logic [7:0]    running_sum_r, running_sum_nxt;
  logic [AW-1:0] rd_ptr_r;
  logic [7:0]    end_r;

  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic [1:0]    out_kind_r;
  logic          out_last_r;

  logic [CMP_W-1:0] hdr_ext, h_eff, count, fl_ext;
  logic [7:0]       fl_now;
  logic [2:0]       evt;

  // Clamp the header length to 2..MAX_FRAME
  always_comb begin
    hdr_ext = CMP_W'(header_bytes_r);
    if (hdr_ext < HDR_MIN) begin
      h_eff = HDR_MIN;
    end else if (hdr_ext > MAX_LEN) begin
      h_eff = MAX_LEN;
    end else begin
      h_eff = hdr_ext;
    end
  end

  always_comb begin
    fl_now           = (bytes_received_r == '0) ? in_data_byte : frame_length_r;
    fl_ext           = CMP_W'(fl_now);
    expected_sum_nxt = (bytes_received_r == CW'(1)) ? in_data_byte : expected_sum_r;
    running_sum_nxt  = (bytes_received_r == CW'(1)) ? running_sum_r
                                                    : running_sum_r + in_data_byte;
    count            = CMP_W'(bytes_received_r) + CMP_W'(1);
    frame_length_nxt = fl_now;
    bytes_received_nxt = bytes_received_r + CW'(1);

    if (count < h_eff) begin
      evt = EV_NONE;
    end else if (fl_ext < h_eff || fl_ext > MAX_LEN) begin
      evt = EV_BAD_LEN;
    end else if (count < fl_ext) begin
      evt = EV_NONE;
    end else if (running_sum_nxt != expected_sum_nxt) begin
      evt = EV_MISMATCH;
    end else if (fl_ext == h_eff) begin
      evt = EV_EMPTY;
    end else begin
      evt = EV_REPLAY;
    end
  end

  assign stat.evt      = evt;
  assign stat.out_free = !out_valid_r || !out_stall;
  assign stat.rd_last  = (CMP_W'(rd_ptr_r) + CMP_W'(1)) == CMP_W'(end_r);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mem[bytes_received_r[AW-1:0]] <= in_data_byte;
    end
    rd_data_r <= mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_bytes_r   <= HDR_RESET;
      bytes_received_r <= '0;
      frame_length_r   <= '0;
      expected_sum_r   <= '0;
      running_sum_r    <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        header_bytes_r <= cfg_header_bytes;
      end
      if (cmd.accept) begin
        // drop the frame once it produces an outcome
        if (evt != EV_NONE) begin
          bytes_received_r <= '0;
          frame_length_r   <= '0;
          expected_sum_r   <= '0;
          running_sum_r    <= '0;
        end else begin
          bytes_received_r <= bytes_received_nxt;
          frame_length_r   <= frame_length_nxt;
          expected_sum_r   <= expected_sum_nxt;
          running_sum_r    <= running_sum_nxt;
        end
      end
      if (cmd.load_status || cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_replay) begin
      rd_ptr_r <= h_eff[AW-1:0];
      end_r    <= fl_now;
    end else if (cmd.emit) begin
      rd_ptr_r <= rd_ptr_r + AW'(1);
    end
    if (cmd.load_status) begin
      out_byte_r <= 8'd0;
      out_kind_r <= cmd.status_kind;
      out_last_r <= 1'b1;
    end else if (cmd.emit) begin
      out_byte_r <= rd_data_r;
      out_kind_r <= KIND_PAYLOAD;
      out_last_r <= stat.rd_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_byte_r;
  assign out_item_kind    = out_kind_r;
  assign out_last_item    = out_last_r;

endmodule

// ===== rtl/lfc_ctrl.sv =====
// Sequencer for byte intake and payload replay of the frame checker.
module lfc_ctrl
  import lfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  lfc_stat_t stat,
  output lfc_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign in_stall = !((state_r == S_IDLE) && stat.out_free);

  always_comb begin
    state_nxt        = state_r;
    cmd.accept       = 1'b0;
    cmd.load_status  = 1'b0;
    cmd.status_kind  = KIND_BAD_LEN;
    cmd.start_replay = 1'b0;
    cmd.emit         = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.accept = 1'b1;
          case (stat.evt)
            EV_BAD_LEN: begin
              cmd.load_status = 1'b1;
              cmd.status_kind = KIND_BAD_LEN;
            end
            EV_MISMATCH: begin
              cmd.load_status = 1'b1;
              cmd.status_kind = KIND_MISMATCH;
            end
            EV_EMPTY: begin
              cmd.load_status = 1'b1;
              cmd.status_kind = KIND_EMPTY;
            end
            EV_REPLAY: begin
              cmd.start_replay = 1'b1;
              state_nxt        = S_RD;
            end
            default: begin
            end
          endcase
        end
      end
      // wait in this state for the store read
      S_RD: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = stat.rd_last ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== tb/length_prefixed_frame_checker_tb.sv =====
// Testbench for the length-prefixed frame checker: directed frames, then random frames per phase.
`timescale 1ns / 1ps

module length_prefixed_frame_checker_tb
  import lfc_pkg::*;
();

  localparam int FRAME_MAX = 64;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_BYTES = 8;

  typedef struct packed {
    logic [7:0] pbyte;
    logic [1:0] kind;
    logic       last;
  } frame_item_t;

  typedef struct packed {
    logic       is_cfg;
    logic [7:0] val;
    logic       typed;
    logic [1:0] kind;
  } dir_row_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [4:0] cfg_header_bytes = HDR_RESET;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_payload_byte;
  logic [1:0] out_item_kind;
  logic       out_last_item;

  // Shadow state of the frame checker
  logic [7:0] frame_buf [0:FRAME_MAX-1];
  int         rx_count;
  logic [7:0] frame_len;
  logic [7:0] sum_field;
  logic [7:0] run_sum;
  logic [4:0] hdr_reg;

  frame_item_t frame_results [$];
  frame_item_t pending_items [$];

  dir_row_t dir_rows [0:31];
  int n_rows;

  int snd_idle;
  int rcv_stall;
  int err_count;
  int bytes_in;
  int hdr_writes;
  int n_payload, n_empty, n_mismatch, n_badlen;

  length_prefixed_frame_checker #(.MAX_FRAME(FRAME_MAX)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_header_bytes (cfg_header_bytes),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_item_kind    (out_item_kind),
    .out_last_item    (out_last_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int eff_hdr();
    int h;
    h = int'(hdr_reg);
    if (h < 2) h = 2;
    if (h > FRAME_MAX) h = FRAME_MAX;
    return h;
  endfunction

  task frame_clear();
    rx_count = 0;
    frame_len = 8'h00;
    sum_field = 8'h00;
    run_sum = 8'h00;
  endtask

  // Work out the result items that one received byte causes
  task frame_outcome(input logic [7:0] b);
    int h, pos, cnt, i;
    frame_item_t it;
    h = eff_hdr();
    frame_results.delete();
    pos = rx_count;
    if (pos >= FRAME_MAX) begin
      frame_clear();
      pos = 0;
    end
    frame_buf[pos] = b;
    if (pos == 0) frame_len = b;
    if (pos == 1) sum_field = b;
    else run_sum = run_sum + b;
    cnt = pos + 1;
    rx_count = cnt;
    if (cnt < h) return;
    if (frame_len < h || frame_len > FRAME_MAX) begin
      it.pbyte = 8'h00;
      it.kind = KIND_BAD_LEN;
      it.last = 1'b1;
      frame_results.push_back(it);
      frame_clear();
      return;
    end
    if (cnt < frame_len) return;
    if (run_sum != sum_field) begin
      it.pbyte = 8'h00;
      it.kind = KIND_MISMATCH;
      it.last = 1'b1;
      frame_results.push_back(it);
    end else if (frame_len == h) begin
      it.pbyte = 8'h00;
      it.kind = KIND_EMPTY;
      it.last = 1'b1;
      frame_results.push_back(it);
    end else begin
      for (i = h; i < frame_len; i++) begin
        it.pbyte = frame_buf[i];
        it.kind = KIND_PAYLOAD;
        it.last = (i + 1 == frame_len);
        frame_results.push_back(it);
      end
    end
    frame_clear();
  endtask

  // Drive one byte, hold it until taken, then record what it should cause
  task send_byte(input logic [7:0] b, input logic typed, input logic [1:0] kind);
    frame_item_t it;
    if (snd_idle > 0 && $urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < snd_idle);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_in++;
    frame_outcome(b);
    if (typed) begin
      it.pbyte = 8'h00;
      it.kind = kind;
      it.last = 1'b1;
      pending_items.push_back(it);
    end else begin
      foreach (frame_results[i]) pending_items.push_back(frame_results[i]);
    end
  endtask

  // Write the header length once the block has gone quiet
  task write_header(input logic [4:0] v);
    in_valid <= 1'b0;
    while (pending_items.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_header_bytes <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    hdr_reg = v;
    hdr_writes++;
  endtask

  task send_frame(input int h);
    int sel, flen, nb, i;
    logic [7:0] fb [0:FRAME_MAX-1];
    logic [7:0] sum;
    sel = $urandom_range(0, 9);
    if (sel < 8) begin
      if ($urandom_range(0, 7) == 0) flen = FRAME_MAX;
      else flen = h + $urandom_range(0, 6);
      if (flen > FRAME_MAX) flen = FRAME_MAX;
    end else if (sel == 8) begin
      if ($urandom_range(0, 1) == 0) flen = $urandom_range(0, h - 1);
      else flen = $urandom_range(FRAME_MAX + 1, 255);
    end else begin
      flen = $urandom_range(0, 255);
    end
    nb = (flen < h || flen > FRAME_MAX) ? h : flen;
    fb[0] = 8'(flen);
    for (i = 1; i < nb; i++) fb[i] = 8'($urandom_range(0, 255));
    sum = 8'h00;
    for (i = 0; i < nb; i++) if (i != 1) sum = sum + fb[i];
    // Correct checksum for sel below 7, one bit flipped for a guaranteed mismatch at sel 7, random otherwise
    if (sel < 7) fb[1] = sum;
    else if (sel == 7) fb[1] = sum ^ (8'h01 << $urandom_range(0, 7));
    for (i = 0; i < nb; i++) send_byte(fb[i], 1'b0, KIND_PAYLOAD);
  endtask

  task add_row(input logic is_cfg, input logic [7:0] val, input logic typed,
               input logic [1:0] kind);
    dir_rows[n_rows] = {is_cfg, val, typed, kind};
    n_rows++;
  endtask

  always @(posedge clk) begin
    frame_item_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got.pbyte = out_payload_byte;
      got.kind = out_item_kind;
      got.last = out_last_item;
      case (got.kind)
        KIND_PAYLOAD:  n_payload++;
        KIND_EMPTY:    n_empty++;
        KIND_MISMATCH: n_mismatch++;
        default:       n_badlen++;
      endcase
      if (pending_items.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("%0t: unexpected item: byte %h kind %0d last %0d",
                   $realtime, got.pbyte, got.kind, got.last);
      end else begin
        want = pending_items.pop_front();
        if (got.pbyte !== want.pbyte || got.kind !== want.kind ||
            got.last !== want.last) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: expected byte %h kind %0d last %0d, got %h kind %0d last %0d",
                     $realtime, want.pbyte, want.kind, want.last,
                     got.pbyte, got.kind, got.last);
        end
      end
    end
    out_stall <= (rcv_stall > 0) && ($urandom_range(0, 99) < rcv_stall);
  end

  initial begin
    logic [4:0] hdr_plan [0:7];
    int p, r, start, w;
    hdr_plan[0] = 5'd2;  hdr_plan[1] = 5'd16; hdr_plan[2] = 5'd5; hdr_plan[3] = 5'd31;
    hdr_plan[4] = 5'd0;  hdr_plan[5] = 5'd1;  hdr_plan[6] = HDR_RESET; hdr_plan[7] = 5'd2;
    err_count = 0; bytes_in = 0; hdr_writes = 0;
    n_payload = 0; n_empty = 0; n_mismatch = 0; n_badlen = 0;
    snd_idle = 18; rcv_stall = 18;
    hdr_reg = HDR_RESET;
    frame_clear();

    n_rows = 0;
    add_row(1'b1, 8'd2, 1'b0, KIND_PAYLOAD);
    add_row(1'b0, 8'h00, 1'b0, KIND_PAYLOAD);     // zero length
    add_row(1'b0, 8'hFF, 1'b1, KIND_BAD_LEN);
    add_row(1'b0, 8'hFF, 1'b0, KIND_PAYLOAD);     // length far past the store
    add_row(1'b0, 8'h00, 1'b1, KIND_BAD_LEN);
    add_row(1'b0, 8'd65, 1'b0, KIND_PAYLOAD);     // one past the store
    add_row(1'b0, 8'h00, 1'b1, KIND_BAD_LEN);
    add_row(1'b0, 8'h02, 1'b0, KIND_PAYLOAD);     // header only, good sum
    add_row(1'b0, 8'h02, 1'b1, KIND_EMPTY);
    add_row(1'b0, 8'h02, 1'b0, KIND_PAYLOAD);     // header only, bad sum
    add_row(1'b0, 8'h03, 1'b1, KIND_MISMATCH);
    add_row(1'b0, 8'h04, 1'b0, KIND_PAYLOAD);     // two payload bytes, sum wraps
    add_row(1'b0, 8'h03, 1'b0, KIND_PAYLOAD);
    add_row(1'b0, 8'hAA, 1'b0, KIND_PAYLOAD);
    add_row(1'b0, 8'h55, 1'b0, KIND_PAYLOAD);
    add_row(1'b1, 8'd0, 1'b0, KIND_PAYLOAD);      // header below minimum, clamps to two
    add_row(1'b0, 8'h03, 1'b0, KIND_PAYLOAD);
    add_row(1'b0, 8'h83, 1'b0, KIND_PAYLOAD);
    add_row(1'b0, 8'h80, 1'b0, KIND_PAYLOAD);
    add_row(1'b1, 8'd3, 1'b0, KIND_PAYLOAD);      // length shorter than the header
    add_row(1'b0, 8'h02, 1'b0, KIND_PAYLOAD);
    add_row(1'b0, 8'h11, 1'b0, KIND_PAYLOAD);
    add_row(1'b0, 8'h22, 1'b1, KIND_BAD_LEN);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < n_rows; r++) begin
      if (dir_rows[r].is_cfg) write_header(dir_rows[r].val[4:0]);
      else send_byte(dir_rows[r].val, dir_rows[r].typed, dir_rows[r].kind);
    end

    for (p = 0; p < 8; p++) begin
      write_header(hdr_plan[p]);
      case (p % 4)
        0: begin snd_idle = 0;  rcv_stall = 0;  end
        1: begin snd_idle = 50; rcv_stall = 0;  end
        2: begin snd_idle = 0;  rcv_stall = 50; end
        default: begin snd_idle = 18; rcv_stall = 18; end
      endcase
      start = bytes_in;
      while (bytes_in - start < PHASE_BYTES) send_frame(eff_hdr());
    end

    in_valid <= 1'b0;
    for (w = 0; w < 100000 && pending_items.size() != 0; w++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_items.size() != 0) begin
      err_count += pending_items.size();
      $display("%0d expected items never arrived", pending_items.size());
    end

    $display("Sent %0d bytes under %0d header settings and four idling patterns.",
             bytes_in, hdr_writes);
    $display("Checked %0d payload bytes, %0d empty frames, %0d bad sums, %0d bad lengths.",
             n_payload, n_empty, n_mismatch, n_badlen);
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lfc_pkg.sv
rtl/lfc_datapath.sv
rtl/lfc_ctrl.sv
rtl/length_prefixed_frame_checker.sv
tb/length_prefixed_frame_checker_tb.sv
